// ----- rtl/plp_pkg.sv -----
// Shared types and codes for the piecewise-linear lookup unit.
package plp_pkg;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    logic               command;
    logic [3:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] sample_x;
  } item_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic               status;
  } result_t;

  // One table entry as held in the point memory.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

endpackage

// ----- rtl/piecewise_linear_lookup_unit.sv -----
// Top level: piecewise-linear interpolation table with a sequential search and divider.
//
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+---------------------------------
//  command  | start_i, busy_o, item_i              | taken when start_i && !busy_o
//  result   | result_valid_o, result_o             | one-cycle strobe, cannot stall
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i | written when valid && ready
//
// A write item leaves busy_o low; it gives no result.
// An evaluate item walks the point memory one slot per cycle (one read port),
// then runs one 32x32 multiply and a 32-step restoring divide. It skips both
// when the sample is clamped at either end of the table or when no segment
// brackets it.
// Reset clears the sequencer and sets point_count to 1; the table is not cleared.
// The result strobe lasts one cycle; a new item may be taken in that same cycle.
module piecewise_linear_lookup_unit #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start_i,
  output logic                              busy_o,
  input  plp_pkg::item_t                    item_i,
  // result channel
  output logic                              result_valid_o,
  output plp_pkg::result_t                  result_o,
  // configuration channel (point_count)
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [plp_pkg::COUNT_W-1:0]       cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  // wide enough for the count register, the write index and MAX_POINTS itself
  localparam int unsigned CNT_W = (AW + 1 > plp_pkg::COUNT_W) ? AW + 1 : plp_pkg::COUNT_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;  // slot 0 on the read port
  localparam logic [2:0] ST_LAST  = 3'd2;  // last slot on the read port
  localparam logic [2:0] ST_SCAN  = 3'd3;  // segment search, one slot per cycle
  localparam logic [2:0] ST_MUL   = 3'd4;  // |dy| * |dx|
  localparam logic [2:0] ST_DIV   = 3'd5;  // restoring divide by |dd|
  localparam logic [2:0] ST_FIN   = 3'd6;  // sign, add y0, saturate

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] a;
    begin
      a = v[32] ? -v : v;
      mag33 = a[31:0];
    end
  endfunction

  logic [2:0]                  state_q, state_d;
  logic [plp_pkg::COUNT_W-1:0] count_q;
  logic signed [31:0]          x_q, x_d;
  plp_pkg::point_t             prev_q, prev_d;
  logic signed [31:0]          ylast_q, ylast_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [31:0]                 mul_a_q, mul_a_d, div_q, div_d;
  logic                        neg_q, neg_d;
  logic [31:0]                 rem_q, rem_d, quo_q, quo_d;
  logic [4:0]                  cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  plp_pkg::result_t            out_q, out_d;

  // memory interface
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  plp_pkg::point_t             ram_wdata, cur;

  // derived
  logic [CNT_W-1:0]            cnt_ext;
  logic [AW-1:0]               last_idx;
  logic                        accept;
  logic signed [32:0]          dy, dx, dd;
  logic                        bracket;
  logic [63:0]                 prod;
  logic [32:0]                 trial;
  logic signed [33:0]          y_off;
  logic signed [34:0]          y_sum;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // count 0 acts as 1, counts above the table size act as the table size
  assign cnt_ext = CNT_W'(count_q);
  always_comb begin
    if (cnt_ext == '0) begin
      last_idx = '0;
    end else if (cnt_ext > CNT_W'(MAX_POINTS)) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(cnt_ext - CNT_W'(1));
    end
  end

  // writes beyond the table are dropped
  assign ram_we    = accept && (item_i.command == plp_pkg::CMD_WRITE) &&
                     (CNT_W'(item_i.point_index) < CNT_W'(MAX_POINTS));
  assign ram_waddr = AW'(item_i.point_index);
  assign ram_wdata = '{x: item_i.point_x, y: item_i.point_y};

  plp_ram #(
    .WIDTH ($bits(plp_pkg::point_t)),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (ram_raddr),
    .rd_data_o (cur)
  );

  // segment math off the previous point and the one just read
  assign dy = 33'(cur.y) - 33'(prev_q.y);
  assign dx = 33'(x_q) - 33'(prev_q.x);
  assign dd = 33'(cur.x) - 33'(prev_q.x);
  assign bracket = ((x_q >= prev_q.x) && (x_q < cur.x)) ||
                   ((x_q <= prev_q.x) && (x_q > cur.x));

  // |dy| * |dx| off the registered operands
  assign prod  = 64'(mul_a_q) * 64'(rem_q);
  assign trial = {rem_q, quo_q[31]};
  assign y_off = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign y_sum = 35'(prev_q.y) + 35'(y_off);

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    prev_d      = prev_q;
    ylast_d     = ylast_q;
    idx_d       = idx_q;
    mul_a_d     = mul_a_q;
    div_d       = div_q;
    neg_d       = neg_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    ram_raddr   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.command == plp_pkg::CMD_EVAL)) begin
          x_d     = item_i.sample_x;
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (x_q <= cur.x) begin
          out_d       = '{result_y: cur.y, status: 1'b0};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          prev_d    = cur;
          ram_raddr = last_idx;
          state_d   = ST_LAST;
        end
      end
      ST_LAST: begin
        if (x_q >= cur.x) begin
          out_d       = '{result_y: cur.y, status: 1'b0};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          // here at least two points are in use
          ylast_d   = cur.y;
          idx_d     = AW'(1);
          ram_raddr = AW'(1);
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (bracket) begin
          mul_a_d = mag33(dy);
          div_d   = mag33(dd);
          rem_d   = mag33(dx);  // parked here until the multiply
          neg_d   = dy[32] ^ dx[32] ^ dd[32];
          state_d = ST_MUL;
        end else if (idx_q == last_idx) begin
          // non-monotone table with no segment around the sample
          out_d       = '{result_y: ylast_q, status: 1'b1};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          prev_d    = cur;
          idx_d     = AW'(idx_q + 1'b1);
          ram_raddr = AW'(idx_q + 1'b1);
        end
      end
      ST_MUL: begin
        // |dx| < |dd| keeps the quotient in 32 bits, so the high half is
        // already below the divisor
        state_d = ST_DIV;
        cnt_d   = 5'd31;
        {rem_d, quo_d} = prod;
      end
      ST_DIV: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = 32'(trial - {1'b0, div_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (y_sum > 35'sh07FFFFFFF) begin
          out_d.result_y = 32'sh7FFFFFFF;
        end else if (y_sum < -35'sh080000000) begin
          out_d.result_y = 32'sh80000000;
        end else begin
          out_d.result_y = y_sum[31:0];
        end
        out_d.status = 1'b0;
        out_valid_d  = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= plp_pkg::COUNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    prev_q  <= prev_d;
    ylast_q <= ylast_d;
    idx_q   <= idx_d;
    mul_a_q <= mul_a_d;
    div_q   <= div_d;
    neg_q   <= neg_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    out_q   <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

// ----- rtl/plp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module plp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the piecewise-linear lookup unit: command, result and count channels.
module tb_top;

  localparam int TABLE_DEPTH    = 16;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 60;
  localparam int ITEM_W         = $bits(plp_pkg::item_t);

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_NO_SEGMENT = 1'b1;

  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  plp_pkg::item_t               item_i;
  logic                         result_valid_o;
  plp_pkg::result_t             result_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [plp_pkg::COUNT_W-1:0]  cfg_data_i;

  // Bench copy of the table and the count register.
  logic signed [31:0]           knot_x [TABLE_DEPTH];
  logic signed [31:0]           knot_y [TABLE_DEPTH];
  logic [plp_pkg::COUNT_W-1:0]  point_count;

  plp_pkg::result_t             expected_lookups [$];
  int                           idle_pct;
  int                           error_count;
  int                           cycle_count = 0;

  piecewise_linear_lookup_unit #(
    .MAX_POINTS(TABLE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run-away guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Count register as the block uses it: 0 acts as 1, above depth clamps.
  function automatic int active_points();
    int n;
    n = point_count;
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  // Expected lookup: clamp at the table ends, else first bracketing segment, else
  // last y, no-segment status; exact product, quotient truncated toward zero, sum saturated.
  function automatic plp_pkg::result_t interpolate_at(logic signed [31:0] sample);
    plp_pkg::result_t r;
    int               n;
    longint           x, x0, x1, y0, dy, dx, dd, yq, sum;
    logic [63:0]      ady, adx, add, q;
    bit               neg;
    n = active_points();
    x = sample;
    r.status = STATUS_OK;
    if (x <= longint'(knot_x[0])) begin
      r.result_y = knot_y[0];
    end else if (x >= longint'(knot_x[n-1])) begin
      r.result_y = knot_y[n-1];
    end else begin
      r.result_y = knot_y[n-1];
      r.status   = STATUS_NO_SEGMENT;
      for (int i = 0; i + 1 < n; i++) begin
        x0 = knot_x[i];
        x1 = knot_x[i+1];
        if (r.status == STATUS_NO_SEGMENT &&
            ((x >= x0 && x < x1) || (x <= x0 && x > x1))) begin
          y0  = knot_y[i];
          dy  = longint'(knot_y[i+1]) - y0;
          dx  = x - x0;
          dd  = x1 - x0;
          neg = ((dy < 0) != (dx < 0)) != (dd < 0);
          ady = (dy < 0) ? -dy : dy;
          adx = (dx < 0) ? -dx : dx;
          add = (dd < 0) ? -dd : dd;
          q   = (ady * adx) / add;     // bracket guarantees add != 0
          q   = q & 64'h3_FFFF_FFFF;
          yq  = neg ? -longint'(q) : longint'(q);
          if (dy == 0 || dx == 0) yq = 0;
          sum = y0 + yq;
          if (sum > Y_MAX) sum = Y_MAX;
          else if (sum < Y_MIN) sum = Y_MIN;
          r.result_y = sum[31:0];
          r.status   = STATUS_OK;
        end
      end
    end
    return r;
  endfunction

  function automatic plp_pkg::item_t write_cmd(logic [3:0] slot, logic [31:0] px,
                                               logic [31:0] py);
    plp_pkg::item_t it;
    it.command     = plp_pkg::CMD_WRITE;
    it.point_index = slot;
    it.point_x     = px;
    it.point_y     = py;
    it.sample_x    = $urandom;
    return it;
  endfunction

  function automatic plp_pkg::item_t eval_cmd(logic [31:0] sx);
    plp_pkg::item_t it;
    it.command     = plp_pkg::CMD_EVAL;
    it.point_index = 4'($urandom);
    it.point_x     = $urandom;
    it.point_y     = $urandom;
    it.sample_x    = sx;
    return it;
  endfunction

  // Drive one item, wait for the block to take it, update the table copy or
  // queue the expected lookup, then maybe leave start low for a while.
  task automatic send_item(plp_pkg::item_t it);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    if (it.command == plp_pkg::CMD_WRITE) begin
      knot_x[it.point_index] = it.point_x;
      knot_y[it.point_index] = it.point_y;
    end else begin
      expected_lookups.push_back(interpolate_at(it.sample_x));
    end
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      item_i  <= ITEM_W'({$urandom, $urandom, $urandom, $urandom});
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Block idle: nothing pending and any write item long finished.
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_point_count(logic [plp_pkg::COUNT_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    point_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Sample choice: mostly inside a segment or on a knot, some anywhere.
  function automatic logic [31:0] pick_sample();
    int          n, sel, k;
    longint      lo, hi, s;
    logic [63:0] off;
    logic [31:0] v;
    n   = active_points();
    sel = $urandom_range(99);
    if (sel < 45 && n > 1) begin
      k  = $urandom_range(n - 2);
      lo = knot_x[k];
      hi = knot_x[k+1];
      if (hi < lo) begin
        s  = lo;
        lo = hi;
        hi = s;
      end
      off = {$urandom, $urandom} % (64'(hi - lo) + 64'd1);
      s   = lo + longint'(off);
      v   = s[31:0];
    end else if (sel < 65) begin
      v = knot_x[$urandom_range(n - 1)];
    end else if (sel < 75) begin
      v = knot_x[$urandom_range(n - 1)] + ($urandom_range(1) ? 32'd1 : -32'd1);
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Fresh content for slots 0..n-1: rising (sometimes with repeated x),
  // falling, or scrambled abscissas; wide or narrow ordinates.
  task automatic load_table(int n);
    logic signed [31:0] xs [TABLE_DEPTH];
    logic [31:0]        y;
    int unsigned        step_max, room;
    longint             acc;
    int                 shape;
    bit                 wide_y;
    shape = $urandom_range(99);
    case ($urandom_range(3))
      0:       step_max = 16;
      1:       step_max = 1 << 12;
      2:       step_max = 1 << 20;
      default: step_max = 1 << 27;
    endcase
    room   = 32'hFFFF_FFFF - 15 * step_max;
    acc    = Y_MIN + longint'($urandom_range(room));
    wide_y = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      xs[i] = acc[31:0];
      acc   = acc + $urandom_range((shape < 15) ? 0 : 1, step_max);
    end
    for (int i = 0; i < n; i++) begin
      y = wide_y ? $urandom : 32'($urandom_range(32'h000F_FFFF)) - 32'h0008_0000;
      if (shape >= 90)      send_item(write_cmd(4'(i), $urandom, y));
      else if (shape >= 80) send_item(write_cmd(4'(i), xs[n-1-i], y));
      else                  send_item(write_cmd(4'(i), xs[i], y));
    end
  endtask

  function automatic logic [plp_pkg::COUNT_W-1:0] pick_count();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5)  return '0;
    if (sel < 15) return plp_pkg::COUNT_W'($urandom_range(31, TABLE_DEPTH + 1));
    if (sel < 25) return plp_pkg::COUNT_W'(1);
    if (sel < 40) return plp_pkg::COUNT_W'(TABLE_DEPTH);
    return plp_pkg::COUNT_W'($urandom_range(TABLE_DEPTH - 1, 2));
  endfunction

  // After reset the count is 1: one knot answers every sample.
  task automatic test_single_point();
    send_item(write_cmd(4'd0, 32'sh0001_8000, 32'sh8000_0000));
    send_item(eval_cmd(32'h8000_0000));
    send_item(eval_cmd(32'h7FFF_FFFF));
  endtask

  // Sixteen knots spread over the whole x range, y swinging rail to rail,
  // so products and quotients reach their widest.
  task automatic test_full_span();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_item(write_cmd(4'(i), 32'h8000_0000 + i * 32'h1111_1111,
                          i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF));
    end
    write_point_count(plp_pkg::COUNT_W'(TABLE_DEPTH));
    send_item(eval_cmd(32'h8000_0000 + 32'h1111_1110));
    send_item(eval_cmd(32'h8000_0001));
    send_item(eval_cmd(32'h8000_0000 + 7 * 32'h1111_1111));
    send_item(eval_cmd(32'h0000_0000));
    send_item(eval_cmd(32'h7FFF_FFFE));
  endtask

  // Count 0 behaves as one knot, counts past the depth as the full table.
  task automatic test_count_limits();
    write_point_count('0);
    send_item(eval_cmd(32'h1234_5678));
    write_point_count('1);
    send_item(eval_cmd(32'hF000_0001));
  endtask

  task automatic test_random_traffic(int pct, int n_items);
    int sent, n;
    idle_pct = pct;
    sent     = 0;
    while (sent < n_items) begin
      write_point_count(pick_count());
      n = active_points();
      load_table(n);
      sent += n;
      repeat ($urandom_range(30, 8)) begin
        if ($urandom_range(99) < 8)
          send_item(write_cmd(4'($urandom), $urandom, $urandom));
        else
          send_item(eval_cmd(pick_sample()));
        sent++;
      end
    end
  endtask

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  // Results cannot be held off: check every strobe against the oldest lookup.
  always @(posedge clk_i) begin
    plp_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_lookups.size() == 0) begin
        error_count++;
        $display("%0t: result with none pending, expected nothing, got y=%h status=%b",
                 $time, result_o.result_y, result_o.status);
      end else begin
        want = expected_lookups.pop_front();
        if (result_o.result_y !== want.result_y)
          report_mismatch("result_y", want.result_y, result_o.result_y);
        if (result_o.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(result_o.status));
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    idle_pct    = 0;
    error_count = 0;
    point_count = plp_pkg::COUNT_W'(1);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_point();
    test_full_span();
    test_count_limits();
    test_random_traffic(0, 310);
    test_random_traffic(63, 310);
    test_random_traffic(34, 310);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_lookups.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/plp_pkg.sv
rtl/plp_ram.sv
rtl/piecewise_linear_lookup_unit.sv
bench/tb_top.sv
